[rtl/rss_pkg.sv]
// Package for the rack stacker sequencer: sizes, codes, reset values and
// the structs shared by the controller, the datapath and the top level.
// No dependencies.
package rss_pkg;

  localparam int RACKS           = 3;
  localparam int RACK_W          = 2;
  localparam int SCALE_FRAC_BITS = 14;

  localparam int TIME_W  = 20;
  localparam int SLOT_W  = 16;
  localparam int SCALE_W = 15;
  localparam int COUNT_W = 4;
  localparam int SETTLE_W = 16;
  localparam int FWAIT_W = 12;
  localparam int PROD_W  = TIME_W + SCALE_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TIME_W-1:0]   TIME_MAX   = {TIME_W{1'b1}};
  localparam logic [SETTLE_W-1:0] SETTLE_MAX = {SETTLE_W{1'b1}};
  localparam logic [FWAIT_W-1:0]  FWAIT_MAX  = {FWAIT_W{1'b1}};
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [FWAIT_W-1:0]  FULL_WAIT_MS = FWAIT_W'(3000);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FULL    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 3'd7;

  localparam logic [SLOT_W-1:0]  SLOT_RST  [3] = '{16'd3500, 16'd2900, 16'd1000};
  localparam logic [SCALE_W-1:0] SCALE_RST [3] = '{15'd16382, 15'd16384, 15'd16220};
  localparam logic [COUNT_W-1:0]  FULL_RST   = 4'd5;
  localparam logic [SETTLE_W-1:0] SETTLE_RST = 16'd1000;

  // Input action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_BOX  = 1'b1;

  // Motor drive codes
  localparam logic [1:0] MOTOR_STOP = 2'd0;
  localparam logic [1:0] MOTOR_FWD  = 2'd1;
  localparam logic [1:0] MOTOR_BACK = 2'd2;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_MOVE = 2'd1,
    PH_DONE = 2'd2,
    PH_HOME = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP
  } ctrl_state_t;

  typedef struct packed {
    logic                 set_pend;
    logic [RACK_W-1:0]    pend_rack;
    logic                 mul;
    logic                 step;
    logic [RACK_W-1:0]    rack;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [RACK_W-1:0]  rack_index;
    logic [1:0]         motor;
    logic [1:0]         phase;
    logic [COUNT_W-1:0] box_count;
    logic               box_counted;
    logic               last;
  } result_t;

endpackage

[rtl/rss_ctrl.sv]
// Controller for the rack stacker sequencer: accepts items and walks the
// racks through multiply and step cycles on each tick.
// Depends on rss_pkg.
module rss_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [rss_pkg::RACK_W-1:0]  in_rack,
  input  rss_pkg::dp_status_t         status,
  output rss_pkg::dp_cmd_t            cmd
);
  import rss_pkg::*;

  ctrl_state_t       state, state_next;
  logic [RACK_W-1:0] rack, rack_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rack  <= '0;
    end else begin
      state <= state_next;
      rack  <= rack_next;
    end
  end

  always_comb begin
    state_next    = state;
    rack_next     = rack;
    in_ready      = 1'b0;
    cmd.set_pend  = 1'b0;
    cmd.pend_rack = in_rack;
    cmd.mul       = 1'b0;
    cmd.step      = 1'b0;
    cmd.rack      = rack;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_BOX) begin
            cmd.set_pend = ({1'b0, in_rack} < (RACK_W+1)'(RACKS));
          end else begin
            rack_next  = '0;
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (rack == RACK_W'(RACKS - 1)) begin
            state_next = ST_IDLE;
          end else begin
            rack_next  = rack + 1'b1;
            state_next = ST_MUL;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/rss_datapath.sv]
// Datapath for the rack stacker sequencer: per-rack state, configuration
// registers, return-length multiplier, rack step logic and result register.
// Depends on rss_pkg.
module rss_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  rss_pkg::cfg_wr_t     cfg,
  input  rss_pkg::dp_cmd_t     cmd,
  output rss_pkg::dp_status_t  status,
  output rss_pkg::result_t     res,
  output logic                 res_valid,
  input  logic                 res_ready
);
  import rss_pkg::*;

  // configuration
  logic [SLOT_W-1:0]   slot_time    [RACKS];
  logic [SCALE_W-1:0]  return_scale [RACKS];
  logic [COUNT_W-1:0]  full_count;
  logic [SETTLE_W-1:0] settle_ms;

  // per-rack state
  phase_t              rack_phase        [RACKS];
  logic [COUNT_W-1:0]  count_store       [RACKS];
  logic                pending_box       [RACKS];
  logic                moving_flag       [RACKS];
  logic                move_dir          [RACKS];
  logic [TIME_W-1:0]   move_elapsed      [RACKS];
  logic [TIME_W-1:0]   move_length       [RACKS];
  logic                settling_flag     [RACKS];
  logic [SETTLE_W-1:0] settle_elapsed    [RACKS];
  logic                full_wait_flag    [RACKS];
  logic [FWAIT_W-1:0]  full_wait_elapsed [RACKS];
  logic [TIME_W-1:0]   moved_total       [RACKS];

  logic [PROD_W-1:0]   prod;

  // next values of the rack being stepped
  phase_t              ph_next;
  logic [COUNT_W-1:0]  cnt_next;
  logic                mv_next, dir_next, st_next, fw_next, counted;
  logic [TIME_W-1:0]   me_next, ml_next, mt_next;
  logic [SETTLE_W-1:0] se_next;
  logic [FWAIT_W-1:0]  fe_next;

  logic [RACK_W-1:0]    r;
  logic [CFG_IDX_W-1:0] scale_idx;

  assign r               = cmd.rack;
  assign scale_idx       = cfg.index - REG_SCALE0;
  assign status.out_free = !res_valid || res_ready;

  always_comb begin
    logic               box, done, start, back;
    logic [TIME_W-1:0]  len;
    logic [PROD_W-1:0]  shifted;
    logic [TIME_W:0]    sum;
    ph_next  = rack_phase[r];
    cnt_next = count_store[r];
    mv_next  = moving_flag[r];
    dir_next = move_dir[r];
    me_next  = move_elapsed[r];
    ml_next  = move_length[r];
    st_next  = settling_flag[r];
    se_next  = settle_elapsed[r];
    fw_next  = full_wait_flag[r];
    fe_next  = full_wait_elapsed[r];
    mt_next  = moved_total[r];
    box      = pending_box[r];
    done     = 1'b0;
    counted  = 1'b0;
    start    = 1'b0;
    back     = 1'b0;
    len      = TIME_W'(slot_time[r]);
    shifted  = prod >> SCALE_FRAC_BITS;
    sum      = '0;

    if (mv_next) begin
      if (me_next != TIME_MAX) me_next = me_next + 1'b1;
      if (me_next >= ml_next) begin
        mv_next = 1'b0;
        done    = 1'b1;
      end
    end
    if (done) box = 1'b0;

    case (ph_next)
      PH_WAIT: begin
        if (st_next) begin
          if (se_next != SETTLE_MAX) se_next = se_next + 1'b1;
        end else if (box) begin
          if (cnt_next != COUNT_MAX) cnt_next = cnt_next + 1'b1;
          counted = 1'b1;
          st_next = 1'b1;
          se_next = '0;
        end
        if (st_next && se_next >= settle_ms) begin
          st_next = 1'b0;
          if (cnt_next >= full_count) begin
            ph_next = PH_DONE;
          end else begin
            ph_next = PH_MOVE;
            start   = 1'b1;
          end
        end
      end
      PH_MOVE: begin
        if (done) ph_next = PH_WAIT;
      end
      PH_DONE: begin
        if (!fw_next) begin
          fw_next = 1'b1;
          fe_next = '0;
        end else if (fe_next != FWAIT_MAX) begin
          fe_next = fe_next + 1'b1;
        end
        if (fe_next > FULL_WAIT_MS) begin
          fw_next = 1'b0;
          ph_next = PH_HOME;
          start   = 1'b1;
          back    = 1'b1;
          // saturate the scaled return length
          len = (shifted > PROD_W'(TIME_MAX)) ? TIME_MAX : shifted[TIME_W-1:0];
        end
      end
      default: begin
        if (done) begin
          cnt_next = '0;
          mt_next  = '0;
          ph_next  = PH_WAIT;
        end
      end
    endcase

    // a zero-length move starts no motion
    if (start && len != '0) begin
      me_next  = '0;
      ml_next  = len;
      mv_next  = 1'b1;
      dir_next = back;
      if (!back) begin
        sum     = {1'b0, mt_next} + {1'b0, len};
        mt_next = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      end
    end
  end

  // return length product, registered ahead of the step cycle
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_W'(moved_total[r]) * PROD_W'(return_scale[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RACKS; i++) begin
        slot_time[i]         <= SLOT_RST[i];
        return_scale[i]      <= SCALE_RST[i];
        rack_phase[i]        <= PH_WAIT;
        count_store[i]       <= '0;
        pending_box[i]       <= 1'b0;
        moving_flag[i]       <= 1'b0;
        move_dir[i]          <= 1'b0;
        move_elapsed[i]      <= '0;
        move_length[i]       <= '0;
        settling_flag[i]     <= 1'b0;
        settle_elapsed[i]    <= '0;
        full_wait_flag[i]    <= 1'b0;
        full_wait_elapsed[i] <= '0;
        moved_total[i]       <= '0;
      end
      full_count <= FULL_RST;
      settle_ms  <= SETTLE_RST;
      res_valid  <= 1'b0;
    end else begin
      if (cfg.wr) begin
        if (cfg.index <= REG_SLOT2) begin
          if ({1'b0, cfg.index[RACK_W-1:0]} < (RACK_W+1)'(RACKS))
            slot_time[cfg.index[RACK_W-1:0]] <= cfg.data;
        end else if (cfg.index <= REG_SCALE2) begin
          if ({1'b0, scale_idx[RACK_W-1:0]} < (RACK_W+1)'(RACKS))
            return_scale[scale_idx[RACK_W-1:0]] <= cfg.data[SCALE_W-1:0];
        end else if (cfg.index == REG_FULL) begin
          full_count <= cfg.data[COUNT_W-1:0];
        end else if (cfg.index == REG_SETTLE) begin
          settle_ms <= cfg.data;
        end
      end

      if (cmd.set_pend) pending_box[cmd.pend_rack] <= 1'b1;

      if (cmd.step) begin
        pending_box[r]       <= 1'b0;
        rack_phase[r]        <= ph_next;
        count_store[r]       <= cnt_next;
        moving_flag[r]       <= mv_next;
        move_dir[r]          <= dir_next;
        move_elapsed[r]      <= me_next;
        move_length[r]       <= ml_next;
        settling_flag[r]     <= st_next;
        settle_elapsed[r]    <= se_next;
        full_wait_flag[r]    <= fw_next;
        full_wait_elapsed[r] <= fe_next;
        moved_total[r]       <= mt_next;
        res_valid            <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      res.rack_index  <= r;
      res.motor       <= mv_next ? (dir_next ? MOTOR_BACK : MOTOR_FWD) : MOTOR_STOP;
      res.phase       <= ph_next;
      res.box_count   <= cnt_next;
      res.box_counted <= counted;
      res.last        <= (r == RACK_W'(RACKS - 1));
    end
  end

endmodule

[rtl/rack_stacker_sequencer_core.sv]
// Rack stacker sequencer: tick-driven per-rack box counting and motion control.
// Box arrival: taken while idle, marks the rack's box pending, no result. Tick:
// each rack in turn takes a multiply and a step state and yields one result; the
// multiplier and step unit are shared, so input waits until the last rack steps.
// A stalled result stretches the step cycle until the output register frees.
// Reset (rst, synchronous): racks wait for a box, counters clear, registers default.
module rack_stacker_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] rack, [7:2] zero
  input  logic        s_axis_tuser,   // [0] action
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] rack_index, [3:2] motor, [5:4] phase,
                                      // [9:6] box_count, [10] box_counted, [15:11] zero
  output logic        m_axis_tlast,   // last
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rss_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  cfg_wr_t    cfg;
  result_t    res;

  // configuration is always taken; write only while no tick is in flight
  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  rss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser),
    .in_rack   (s_axis_tdata[RACK_W-1:0]),
    .status    (status),
    .cmd       (cmd)
  );

  rss_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .res       (res),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready)
  );

  // pack the result fields, lowest field first
  assign m_axis_tdata = {5'b0, res.box_counted, res.box_count, res.phase,
                         res.motor, res.rack_index};
  assign m_axis_tlast = res.last;

endmodule

[rtl/rss_check.sv]
// Port-level checker for the rack stacker sequencer, bound to the top level.
// Depends on rss_pkg.
module rss_check (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import rss_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a tick transfer blocks input while the racks are stepped
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_TICK |=> !s_axis_tready)
    else $error("input taken during tick processing");

  // last marks exactly the final rack
  a_last_rack: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == 2'(RACKS - 1))))
    else $error("last does not match final rack");

  // a full rack waiting to return is never driven
  a_done_still: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5:4] == PH_DONE |-> m_axis_tdata[3:2] == MOTOR_STOP)
    else $error("motor running in done phase");

endmodule

bind rack_stacker_sequencer_core rss_check u_rss_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
